// ===== rtl/xrg_pkg.sv =====
// ----------------------------------------------------------------------------
// xrg_pkg
// Shared types and constants of the xorshift128 range generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xrg_pkg;

	// request codes
	localparam logic [1:0] REQ_RESEED = 2'd0;
	localparam logic [1:0] REQ_RAW    = 2'd1;
	localparam logic [1:0] REQ_RANGE  = 2'd2;

	// xorshift128 initial state and shift amounts
	localparam logic [31:0] INIT_A = 32'd123456789;
	localparam logic [31:0] INIT_B = 32'd362436069;
	localparam logic [31:0] INIT_C = 32'd521288629;
	localparam logic [31:0] INIT_D = 32'd88675123;
	localparam int unsigned SHIFT_A = 11;
	localparam int unsigned SHIFT_D = 19;
	localparam int unsigned SHIFT_T = 8;

	// one quotient bit per divider step
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic capture;   // latch the accepted request
		logic exec;      // reseed or advance, arm the divider
		logic div_step;  // one restoring divider step
		logic load_out;  // move the result into the output register
	} xrg_cmd_t;

	typedef struct packed {
		logic need_div;  // range draw with a nonzero span
		logic div_last;  // divider is on its final step
		logic out_free;  // output register can take a result this cycle
	} xrg_sts_t;

endpackage

`default_nettype wire

// ===== rtl/xrg_if.sv =====
// ----------------------------------------------------------------------------
// xrg request and response channels
// Valid/ready stream interfaces carrying the request and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface xrg_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] range_min;
	logic [31:0] range_max;

	modport source (output valid, output req_type, output range_min, output range_max,
		input ready);
	modport sink (input valid, input req_type, input range_min, input range_max,
		output ready);
endinterface

interface xrg_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] draw_value;
	logic        zero_span;

	modport source (output valid, output draw_value, output zero_span, input ready);
	modport sink (input valid, input draw_value, input zero_span, output ready);
endinterface

`default_nettype wire

// ===== rtl/xrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// xrg_ctrl
// Sequencer: accept a request, execute it, run the divider, hand off result.
// ----------------------------------------------------------------------------
`default_nettype none

module xrg_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output xrg_pkg::xrg_cmd_t     cmd,
	input  wire xrg_pkg::xrg_sts_t sts
);
	import xrg_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.need_div ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// hold until the output register frees up
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_EXEC)
		else $error("accepted beat did not start execution");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && sts.div_last |=> state_q == S_DONE)
		else $error("divider overran its step count");
	a_no_div_skip: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC && !sts.need_div |=> state_q == S_DONE)
		else $error("divider started without a nonzero span");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over a pending beat");
`endif

endmodule

`default_nettype wire

// ===== rtl/xrg_dp.sv =====
// ----------------------------------------------------------------------------
// xrg_dp
// State words, seed register, restoring divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xrg_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire xrg_pkg::xrg_cmd_t cmd,
	output xrg_pkg::xrg_sts_t     sts,
	input  wire logic [1:0]       req_type,
	input  wire logic [31:0]      range_min,
	input  wire logic [31:0]      range_max,
	input  wire logic             seed_we,
	input  wire logic [63:0]      seed_wdata,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [31:0]           draw_value,
	output logic                  zero_span
);
	import xrg_pkg::*;

	logic [63:0]      seed_q;
	logic [31:0]      word_a_q, word_b_q, word_c_q, word_d_q;
	logic [1:0]       req_q;
	logic [31:0]      min_q, max_q;
	logic [31:0]      rem_q, dvd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [31:0]      value_q;
	logic             flag_q;

	logic [31:0] span;
	logic [31:0] t_mix;
	logic [31:0] word_next;
	logic [32:0] rem_shift;
	logic [32:0] rem_diff;
	logic [31:0] result;
	logic        result_flag;

	assign span      = max_q - min_q;
	assign t_mix     = word_a_q ^ (word_a_q << SHIFT_A);
	assign word_next = word_d_q ^ (word_d_q >> SHIFT_D) ^ t_mix ^ (t_mix >> SHIFT_T);

	// restoring step: bring in the next dividend bit, subtract if it fits
	assign rem_shift = {rem_q, dvd_q[31]};
	assign rem_diff  = rem_shift - {1'b0, span};

	assign sts.need_div = (req_q == REQ_RANGE) && (span != '0);
	assign sts.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		result      = '0;
		result_flag = 1'b0;
		case (req_q)
			REQ_RAW: begin
				result = word_d_q;
			end
			REQ_RANGE: begin
				if (span == '0) begin
					result      = min_q;
					result_flag = 1'b1;
				end else begin
					result = rem_q + min_q;
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			word_a_q <= INIT_A;
			word_b_q <= INIT_B;
			word_c_q <= INIT_C;
			word_d_q <= INIT_D;
		end else begin
			if (seed_we) begin
				seed_q <= seed_wdata;
			end
			if (cmd.exec) begin
				if (req_q == REQ_RESEED) begin
					word_a_q <= INIT_A ^ seed_q[63:32];
					word_b_q <= INIT_B ^ seed_q[31:0];
					word_c_q <= INIT_C ^ seed_q[63:32];
					word_d_q <= INIT_D ^ seed_q[31:0];
				end else if (req_q == REQ_RAW || req_q == REQ_RANGE) begin
					word_a_q <= word_b_q;
					word_b_q <= word_c_q;
					word_c_q <= word_d_q;
					word_d_q <= word_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			min_q <= range_min;
			max_q <= range_max;
		end
		if (cmd.exec) begin
			// new word becomes the dividend
			dvd_q <= word_next;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= rem_diff[32] ? rem_shift[31:0] : rem_diff[31:0];
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.load_out) begin
			value_q <= result;
			flag_q  <= result_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign draw_value = value_q;
	assign zero_span  = flag_q;

endmodule

`default_nettype wire

// ===== rtl/xorshift128_range_generator.sv =====
// ----------------------------------------------------------------------------
// xorshift128_range_generator
// Xorshift128 generator serving reseed, raw draw and range draw requests.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | beat
//  ---------+-----+--------------------+----------------------------------
//  req      | in  | req.valid/ready    | req_type, range_min, range_max
//  rsp      | out | rsp.valid/ready    | draw_value, zero_span
//  seed     | in  | seed_we            | seed_wdata (64-bit seed)
//
//  One request at a time: reseed and raw draws pass through execute and done;
//  a range draw with a nonzero span also runs the one-bit-per-cycle divider.
//  A finished result waits in the output register while the next beat is taken.
//  Reset loads the published xorshift128 state and clears the seed to zero.
//  A stalled response holds the sequencer only when a second result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift128_range_generator (
	input  wire logic   clk,
	input  wire logic   arst_n,
	xrg_req_if.sink     req,
	xrg_rsp_if.source   rsp,
	input  wire logic        seed_we,
	input  wire logic [63:0] seed_wdata
);
	import xrg_pkg::*;

	xrg_cmd_t cmd;
	xrg_sts_t sts;

	xrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	xrg_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req.req_type),
		.range_min  (req.range_min),
		.range_max  (req.range_max),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.draw_value (rsp.draw_value),
		.zero_span  (rsp.zero_span)
	);

endmodule

`default_nettype wire

// ===== dv/xorshift128_range_generator_test.sv =====
// ----------------------------------------------------------------------------
// xorshift128_range_generator_test
// Drives reseed, raw draw, range draw and unused requests into the generator
// and checks every result beat against a pinned answer or an in-bench xorshift128 predictor.
// A directed table comes first, then random requests under several seeds.
// Both channels idle at random, and one long response stall backs up the block.
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift128_range_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import xrg_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int N_DIRECTED = 22;
	localparam int N_PHASES = 7;
	localparam int ITEMS_PER_PHASE = 104;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] lo;
		logic [31:0] hi;
	} draw_req_t;

	typedef struct packed {
		logic [31:0] value;
		logic        zero_span;
	} draw_rsp_t;

	typedef struct packed {
		draw_req_t beat;
		logic      pinned;  // rsp below holds the known answer
		draw_rsp_t rsp;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        seed_we;
	logic [63:0] seed_wdata;

	xrg_req_if req_ch ();
	xrg_rsp_if rsp_ch ();

	xorshift128_range_generator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.seed_we   (seed_we),
		.seed_wdata(seed_wdata)
	);

	// predictor state
	logic [63:0] seed_reg;
	logic [31:0] gen_a, gen_b, gen_c, gen_d;

	draw_rsp_t pending_draws [$];
	int        mismatch_count = 0;
	int        send_run = 0;
	int        recv_run = 0;
	bit        long_hold = 1'b0;

	directed_row_t directed_rows [N_DIRECTED] = '{
		{REQ_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
		{REQ_RAW,    32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		{REQ_RAW,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		{REQ_RANGE,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
		{REQ_RANGE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1},
		{REQ_RANGE,  32'h0000_0005, 32'h0000_0005, 1'b1, 32'h0000_0005, 1'b1},
		{REQ_RANGE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		{REQ_RANGE,  32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b0},
		{REQ_RANGE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
		{REQ_RANGE,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
		{REQ_RANGE,  32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		{REQ_RANGE,  32'h0000_000A, 32'h0000_0014, 1'b0, 32'h0000_0000, 1'b0},
		{REQ_RANGE,  32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		{REQ_RANGE,  32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
		{REQ_RANGE,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000, 1'b0},
		{REQ_RANGE,  32'h0000_0000, 32'h0000_0002, 1'b0, 32'h0000_0000, 1'b0},
		{REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
		{REQ_UNUSED, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		{REQ_RAW,    32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'h0000_0000, 1'b0},
		{REQ_RESEED, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		{REQ_RAW,    32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		{REQ_RANGE,  32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, 1'b1}
	};

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Apply one request to the predictor state and return its result.
	function automatic draw_rsp_t predict_draw(input draw_req_t beat);
		logic [31:0] mix;
		logic [31:0] span;
		draw_rsp_t   rsp;
		rsp = '0;
		span = beat.hi - beat.lo;
		case (beat.kind)
			REQ_RESEED: begin
				gen_a = INIT_A ^ seed_reg[63:32];
				gen_b = INIT_B ^ seed_reg[31:0];
				gen_c = INIT_C ^ seed_reg[63:32];
				gen_d = INIT_D ^ seed_reg[31:0];
			end
			REQ_RAW, REQ_RANGE: begin
				mix = gen_a ^ (gen_a << SHIFT_A);
				gen_a = gen_b;
				gen_b = gen_c;
				gen_c = gen_d;
				gen_d = gen_d ^ (gen_d >> SHIFT_D) ^ mix ^ (mix >> SHIFT_T);
				if (beat.kind == REQ_RAW) begin
					rsp.value = gen_d;
				end else if (span == 32'd0) begin
					rsp.value = beat.lo;
					rsp.zero_span = 1'b1;
				end else begin
					rsp.value = (gen_d % span) + beat.lo;
				end
			end
			default: ;
		endcase
		return rsp;
	endfunction

	// Idle cycles before the next beat; now and then a run with no idling.
	function automatic int draw_gap(inout int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			run_left = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	function automatic draw_req_t make_request();
		draw_req_t beat;
		int        pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			beat.kind = REQ_RESEED;
		else if (pick < 36)
			beat.kind = REQ_RAW;
		else if (pick < 95)
			beat.kind = REQ_RANGE;
		else
			beat.kind = REQ_UNUSED;
		beat.lo = $urandom;
		case ($urandom_range(0, 5))
			0: beat.hi = $urandom;
			1: beat.hi = beat.lo;
			2: beat.hi = beat.lo + $urandom_range(1, 16);
			3: beat.hi = beat.lo - $urandom_range(1, 16);
			4: begin
				beat.lo = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
				beat.hi = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
			end
			default: beat.hi = beat.lo + ($urandom >> $urandom_range(0, 31));
		endcase
		return beat;
	endfunction

	task automatic send_request(input draw_req_t beat, input logic pinned,
		input draw_rsp_t known);
		int        gap;
		draw_rsp_t predicted;
		gap = draw_gap(send_run);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= beat.kind;
		req_ch.range_min <= beat.lo;
		req_ch.range_max <= beat.hi;
		do @(posedge clk); while (!req_ch.ready);
		predicted = predict_draw(beat);
		pending_draws.push_back(pinned ? known : predicted);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
	endtask

	task automatic load_seed(input logic [63:0] value);
		seed_we    <= 1'b1;
		seed_wdata <= value;
		@(posedge clk);
		seed_we  <= 1'b0;
		seed_reg = value;
	endtask

	initial begin : stimulus
		logic [63:0] phase_seeds [N_PHASES];
		draw_req_t   reseed;
		phase_seeds = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, {$urandom, $urandom},
			64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
			{$urandom, $urandom}, {$urandom, $urandom}};
		reseed = '{kind: REQ_RESEED, lo: 32'h0, hi: 32'h0};
		seed_reg = '0;
		gen_a = INIT_A;
		gen_b = INIT_B;
		gen_c = INIT_C;
		gen_d = INIT_D;
		arst_n           <= 1'b0;
		seed_we          <= 1'b0;
		seed_wdata       <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_RESEED;
		req_ch.range_min <= '0;
		req_ch.range_max <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].beat, directed_rows[i].pinned,
				directed_rows[i].rsp);

		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			load_seed(phase_seeds[p]);
			send_request(reseed, 1'b0, '0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// back up the block behind a stalled response channel
				if (p == 1 && i == 20)
					long_hold = 1'b1;
				send_request(make_request(), 1'b0, '0);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : response_ready
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				stall = LONG_HOLD_CYCLES;
				long_hold = 1'b0;
			end else begin
				stall = draw_gap(recv_run);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin : check_draws
		draw_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_draws.size() == 0) begin
				$error("unexpected result beat: draw_value %h zero_span %b",
					rsp_ch.draw_value, rsp_ch.zero_span);
				mismatch_count++;
			end else begin
				want = pending_draws.pop_front();
				if (rsp_ch.draw_value !== want.value) begin
					$error("draw_value: expected %h, actual %h", want.value,
						rsp_ch.draw_value);
					mismatch_count++;
				end
				if (rsp_ch.zero_span !== want.zero_span) begin
					$error("zero_span: expected %b, actual %b", want.zero_span,
						rsp_ch.zero_span);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/xrg_pkg.sv
rtl/xrg_if.sv
rtl/xrg_ctrl.sv
rtl/xrg_dp.sv
rtl/xorshift128_range_generator.sv
dv/xorshift128_range_generator_test.sv
